// File: rtl/bffa_pkg.sv
package bffa_pkg;

	// Fixed field widths of the command and result ports.
	localparam int ENTRY_W = 14;
	localparam int STAT_W  = 2;

	// Command codes.
	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	// Result status codes.
	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_RANGE     = 2'd2,
		ST_NOT_TAKEN = 2'd3
	} status_t;

endpackage

// File: rtl/bitmap_first_fit_allocator_unit.sv
// Allocate: the result strobe follows the accepted transaction once k words are scanned
// (at most MAX_ENTRIES/WORD_BITS, 256 at defaults); one word of the bitmap memory per cycle.
// Free: the result comes after the reciprocal divide, the read and the write back, in that order.
// Rejected commands (empty map on allocate, bad number on free) answer in the cycle after acceptance.
// A new transaction is accepted only after the last has finished; busy is low while the strobe is shown.
// Reset starts a clearing pass over both bitmaps, 2*MAX_ENTRIES/WORD_BITS words (512), busy high.
module bitmap_first_fit_allocator_unit
	import bffa_pkg::*;
#(
	parameter int MAX_ENTRIES = 8192,
	parameter int WORD_BITS   = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cmd,
	input  logic               which_map,
	input  logic [ENTRY_W-1:0] entry_number,
	output logic               done,
	output logic [ENTRY_W-1:0] given_number,
	output logic [STAT_W-1:0]  status,
	output logic [ENTRY_W-1:0] free_left,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [ENTRY_W-1:0] cfg_data
);

	localparam int MAP_WORDS = (MAX_ENTRIES + WORD_BITS - 1) / WORD_BITS;
	localparam int DEPTH     = 2 * MAP_WORDS;
	localparam int AW        = $clog2(DEPTH);
	localparam int WIDX      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int PW        = $clog2(WORD_BITS);
	// Reciprocal of WORD_BITS, one low at most, fixed by one correction step.
	localparam int SH        = ENTRY_W + PW + 1;
	localparam int RCW       = SH - PW + 2;
	localparam int PRW       = ENTRY_W + RCW;
	localparam int QW        = ENTRY_W + 8;
	localparam longint RECIP = (64'd1 << SH) / WORD_BITS;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_SCAN  = 5'b00100,
		S_FDIV  = 5'b01000,
		S_FCHK  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rd_data_q;
	logic                 rd_en, mem_we;
	logic [AW-1:0]        rd_addr, wr_addr;
	logic [WORD_BITS-1:0] wr_data;
	logic [AW-1:0]        clr_addr_q;

	logic [ENTRY_W-1:0] blocks_in_use_q, inodes_in_use_q;
	logic [ENTRY_W-1:0] used_blocks_q, used_inodes_q;

	logic               map_q;
	logic [ENTRY_W-1:0] lim_q, idx_q, rem_q, base_q;
	logic [WIDX-1:0]    wi_q;
	logic [PW-1:0]      bitpos_q;
	logic [PRW-1:0]     prod_q;

	logic               accept;
	logic [ENTRY_W-1:0] lim_reg, lim_in, idx_in;
	logic [ENTRY_W-1:0] sel_lim, used_sel, used_after;
	logic               fin, upd_used;
	logic [ENTRY_W-1:0] fin_given;
	status_t            fin_status;

	logic [WORD_BITS-1:0] free_vec;
	logic                 found;
	logic [PW-1:0]        pos;
	logic                 more_words;

	logic [ENTRY_W-1:0] q0, q_fix;
	logic [QW-1:0]      r0, r_fix;
	logic               corr;

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;

	function automatic logic [AW-1:0] word_addr(input logic m, input logic [WIDX-1:0] w);
		word_addr = (m ? AW'(MAP_WORDS) : AW'(0)) + AW'(w);
	endfunction

	// Limit of the addressed map, clamped to the bitmap size.
	always_comb begin
		lim_reg = which_map ? inodes_in_use_q : blocks_in_use_q;
		lim_in  = (32'(lim_reg) > MAX_ENTRIES) ? ENTRY_W'(MAX_ENTRIES) : lim_reg;
		idx_in  = entry_number - ENTRY_W'(1);
	end

	// First clear bit of the current word that lies below the limit.
	always_comb begin
		pos = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			free_vec[b] = !rd_data_q[b] && (rem_q > ENTRY_W'(b));
		end
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (free_vec[b]) begin
				pos = PW'(b);
			end
		end
		found      = |free_vec;
		more_words = (32'(rem_q) > WORD_BITS);
	end

	// Word index and bit offset of a freed entry from the registered product.
	always_comb begin
		q0    = ENTRY_W'(prod_q >> SH);
		r0    = QW'(idx_q) - QW'(q0) * QW'(WORD_BITS);
		corr  = (r0 >= QW'(WORD_BITS));
		q_fix = corr ? (q0 + ENTRY_W'(1)) : q0;
		r_fix = corr ? (r0 - QW'(WORD_BITS)) : r0;
	end

	// Sequencer: next state, memory port controls and result selection.
	always_comb begin
		state_d    = state_q;
		rd_en      = 1'b0;
		rd_addr    = word_addr(map_q, wi_q + WIDX'(1));
		mem_we     = 1'b0;
		wr_addr    = word_addr(map_q, wi_q);
		wr_data    = rd_data_q;
		fin        = 1'b0;
		upd_used   = 1'b0;
		fin_given  = '0;
		fin_status = ST_OK;
		sel_lim    = lim_q;
		used_sel   = map_q ? used_inodes_q : used_blocks_q;
		used_after = used_sel;
		case (state_q)
			S_CLEAR: begin
				mem_we  = 1'b1;
				wr_addr = clr_addr_q;
				wr_data = '0;
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				sel_lim    = lim_in;
				used_sel   = which_map ? used_inodes_q : used_blocks_q;
				used_after = used_sel;
				rd_addr    = word_addr(which_map, '0);
				if (accept) begin
					if (cmd == CMD_ALLOC) begin
						if (lim_in == '0) begin
							fin        = 1'b1;
							fin_status = ST_FULL;
						end else begin
							rd_en   = 1'b1;
							state_d = S_SCAN;
						end
					end else if (entry_number == '0 || entry_number > lim_in) begin
						fin        = 1'b1;
						fin_status = ST_RANGE;
					end else begin
						state_d = S_FDIV;
					end
				end
			end
			S_SCAN: begin
				rd_en = more_words;
				if (found) begin
					mem_we     = 1'b1;
					wr_data    = rd_data_q | (WORD_BITS'(1) << pos);
					fin        = 1'b1;
					upd_used   = 1'b1;
					used_after = used_sel + ENTRY_W'(1);
					fin_given  = base_q + ENTRY_W'(pos) + ENTRY_W'(1);
					state_d    = S_IDLE;
				end else if (!more_words) begin
					fin        = 1'b1;
					fin_status = ST_FULL;
					state_d    = S_IDLE;
				end
			end
			S_FDIV: begin
				rd_en   = 1'b1;
				rd_addr = word_addr(map_q, WIDX'(q_fix));
				state_d = S_FCHK;
			end
			S_FCHK: begin
				fin     = 1'b1;
				state_d = S_IDLE;
				if (!rd_data_q[bitpos_q]) begin
					fin_status = ST_NOT_TAKEN;
				end else begin
					mem_we     = 1'b1;
					wr_data    = rd_data_q & ~(WORD_BITS'(1) << bitpos_q);
					upd_used   = 1'b1;
					used_after = (used_sel != '0) ? (used_sel - ENTRY_W'(1)) : used_sel;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Bitmap memory: one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Control state, configuration and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_CLEAR;
			clr_addr_q      <= '0;
			blocks_in_use_q <= ENTRY_W'(8192);
			inodes_in_use_q <= ENTRY_W'(8192);
			used_blocks_q   <= '0;
			used_inodes_q   <= '0;
			done            <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= fin;
			if (state_q == S_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == 1'b0) begin
					blocks_in_use_q <= cfg_data;
				end else begin
					inodes_in_use_q <= cfg_data;
				end
			end
			if (upd_used) begin
				if (map_q) begin
					used_inodes_q <= used_after;
				end else begin
					used_blocks_q <= used_after;
				end
			end
		end
	end

	// Operation context and result registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			map_q  <= which_map;
			lim_q  <= lim_in;
			idx_q  <= idx_in;
			prod_q <= PRW'(idx_in) * PRW'(RECIP);
			wi_q   <= '0;
			rem_q  <= lim_in;
			base_q <= '0;
		end else if (state_q == S_SCAN) begin
			wi_q   <= wi_q + WIDX'(1);
			rem_q  <= rem_q - ENTRY_W'(WORD_BITS);
			base_q <= base_q + ENTRY_W'(WORD_BITS);
		end else if (state_q == S_FDIV) begin
			wi_q     <= WIDX'(q_fix);
			bitpos_q <= PW'(r_fix);
		end
		if (fin) begin
			given_number <= fin_given;
			status       <= fin_status;
			free_left    <= (used_after >= sel_lim) ? '0 : (sel_lim - used_after);
		end
	end

	// A result only follows an accepted transaction or work in progress.
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("result strobe without a transaction");

	// Only a successful allocate reports a nonzero entry number.
	a_given_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (given_number == '0))
		else $error("entry number given on a failed command");

	// The bitmaps are never written while the sequencer is idle.
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q != S_IDLE))
		else $error("bitmap write while idle");

	// A scan step always has entries left below the limit.
	a_scan_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (rem_q != '0))
		else $error("scan past the limit");

endmodule

// File: bench/tb.sv
module tb
	import bffa_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAP_ENTRIES = 8192;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 50;

	typedef struct {
		cmd_t               op;
		logic               which_map;
		logic [ENTRY_W-1:0] entry_number;
	} alloc_request_t;

	typedef struct {
		logic [ENTRY_W-1:0] given_number;
		status_t            status;
		logic [ENTRY_W-1:0] free_left;
	} alloc_answer_t;

	// Block inputs, all known from time zero.
	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               start        = 1'b0;
	cmd_t               cmd          = CMD_ALLOC;
	logic               which_map    = 1'b0;
	logic [ENTRY_W-1:0] entry_number = '0;
	logic               cfg_valid    = 1'b0;
	logic               cfg_index    = 1'b0;
	logic [ENTRY_W-1:0] cfg_data     = '0;

	logic               busy;
	logic               done;
	logic [ENTRY_W-1:0] given_number;
	logic [STAT_W-1:0]  status;
	logic [ENTRY_W-1:0] free_left;
	logic               cfg_ready;

	// Shadow of the allocator: both bitmaps, used counts and in-use registers.
	bit                 entry_taken [2][MAP_ENTRIES];
	int unsigned        taken_count [2] = '{0, 0};
	logic [ENTRY_W-1:0] span_reg [2]    = '{14'd8192, 14'd8192};

	alloc_request_t pending_reqs[$];
	alloc_answer_t  awaited_answers[$];
	int             reqs_queued = 0;
	int             reqs_taken  = 0;
	int             fail_count  = 0;
	bit             item_taken  = 1'b0;
	bit             no_gaps     = 1'b0;
	int             gap_left    = 0;

	// Stimulus side view of the limits and of how many allocations were sent.
	int gen_span [2]   = '{MAP_ENTRIES, MAP_ENTRIES};
	int gen_allocs [2] = '{0, 0};

	bitmap_first_fit_allocator_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.which_map    (which_map),
		.entry_number (entry_number),
		.done         (done),
		.given_number (given_number),
		.status       (status),
		.free_left    (free_left),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// A register value above the map size acts as the full map.
	function automatic int span_limit(int m);
		return (span_reg[m] > MAP_ENTRIES) ? MAP_ENTRIES : int'(span_reg[m]);
	endfunction

	// Apply one command to the shadow bitmaps and return the answer it gives.
	function automatic alloc_answer_t predict_answer(alloc_request_t r);
		alloc_answer_t a;
		int m;
		int lim;
		m = r.which_map;
		lim = span_limit(m);
		a.given_number = '0;
		a.status = ST_OK;
		if (r.op == CMD_ALLOC) begin
			// First fit: lowest clear entry below the limit.
			a.status = ST_FULL;
			for (int i = 0; i < lim; i++) begin
				if (!entry_taken[m][i]) begin
					entry_taken[m][i] = 1'b1;
					taken_count[m]++;
					a.given_number = ENTRY_W'(i + 1);
					a.status = ST_OK;
					break;
				end
			end
		end else if (r.entry_number == 0 || r.entry_number > lim) begin
			a.status = ST_RANGE;
		end else if (!entry_taken[m][r.entry_number - 1]) begin
			a.status = ST_NOT_TAKEN;
		end else begin
			entry_taken[m][r.entry_number - 1] = 1'b0;
			if (taken_count[m] > 0)
				taken_count[m]--;
		end
		// The free count saturates when a shrunk map holds more than its limit.
		a.free_left = (taken_count[m] >= lim) ? '0 : ENTRY_W'(lim - taken_count[m]);
		return a;
	endfunction

	function automatic void check_field(string name, logic [ENTRY_W-1:0] want,
			logic [ENTRY_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Driver: presents commands at the falling edge, holds each until accepted.
	always @(negedge clk) begin : driver
		alloc_request_t r;
		if (arst_n) begin
			if (start && !item_taken) begin
				// Transaction not yet accepted; keep it on the ports.
			end else if (gap_left > 0) begin
				start <= 1'b0;
				gap_left = gap_left - 1;
			end else if (pending_reqs.size() > 0) begin
				r = pending_reqs.pop_front();
				start <= 1'b1;
				cmd <= r.op;
				which_map <= r.which_map;
				entry_number <= r.entry_number;
				// Switch now and then between random gaps and back-to-back issue.
				if ($urandom_range(0, 19) == 0)
					no_gaps = !no_gaps;
				gap_left = no_gaps ? 0 : $urandom_range(0, 6);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: checks each result, then records accepted commands and
	// register writes at the rising edge.
	always @(posedge clk) begin : monitor
		alloc_answer_t want;
		alloc_request_t r;
		item_taken = 1'b0;
		if (arst_n) begin
			if (done) begin
				if (awaited_answers.size() == 0) begin
					$error("unexpected result: given_number %0d status %0d free_left %0d",
						given_number, status, free_left);
					fail_count++;
				end else begin
					want = awaited_answers.pop_front();
					check_field("given_number", want.given_number, given_number);
					check_field("status", ENTRY_W'(want.status), ENTRY_W'(status));
					check_field("free_left", want.free_left, free_left);
				end
			end
			if (start && !busy) begin
				item_taken = 1'b1;
				reqs_taken++;
				r.op = cmd;
				r.which_map = which_map;
				r.entry_number = entry_number;
				awaited_answers.push_back(predict_answer(r));
			end
			if (cfg_valid && cfg_ready)
				span_reg[cfg_index] = cfg_data;
		end
	end

	task automatic queue_req(cmd_t op, logic m, logic [ENTRY_W-1:0] num);
		alloc_request_t r;
		r.op = op;
		r.which_map = m;
		r.entry_number = num;
		if (op == CMD_ALLOC)
			gen_allocs[m]++;
		pending_reqs.push_back(r);
		reqs_queued++;
	endtask

	// Mostly allocations and frees of entries likely to be taken, with some
	// frees near and beyond the limit and a little noise.
	task automatic queue_random_req(logic m);
		int sel;
		int hi;
		logic [ENTRY_W-1:0] num;
		sel = $urandom_range(0, 99);
		num = ENTRY_W'($urandom_range(0, 16383));
		if (sel < 55) begin
			queue_req(CMD_ALLOC, m, num);
		end else begin
			if (sel < 85 && gen_span[m] > 0) begin
				hi = (gen_allocs[m] + 3 < gen_span[m]) ? gen_allocs[m] + 3 : gen_span[m];
				num = ENTRY_W'($urandom_range(1, hi));
			end else if (sel < 93) begin
				num = ENTRY_W'($urandom_range(1, gen_span[m] + 3));
			end else begin
				case ($urandom_range(0, 3))
					0: num = '0;
					1: num = ENTRY_W'(gen_span[m] + 1);
					2: num = ENTRY_W'(MAP_ENTRIES);
					default: ;
				endcase
			end
			queue_req(CMD_FREE, m, num);
		end
	endtask

	// Wait until every command has been accepted and answered and the unit is idle.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (reqs_taken != reqs_queued || awaited_answers.size() != 0 || busy !== 1'b0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_span(logic idx, logic [ENTRY_W-1:0] value);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Reprogram both in-use registers between phases.
	task automatic set_spans(logic [ENTRY_W-1:0] blocks, logic [ENTRY_W-1:0] inodes);
		wait_idle();
		write_span(1'b0, blocks);
		write_span(1'b1, inodes);
		gen_span[0] = (blocks > MAP_ENTRIES) ? MAP_ENTRIES : int'(blocks);
		gen_span[1] = (inodes > MAP_ENTRIES) ? MAP_ENTRIES : int'(inodes);
		@(posedge clk);
	endtask

	function automatic logic [ENTRY_W-1:0] draw_span_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 14'd1;
			2: return 14'd8192;
			3: return 14'd16383;
			4, 5, 8: return ENTRY_W'($urandom_range(2, 48));
			6: return ENTRY_W'($urandom_range(49, 8191));
			7: return ENTRY_W'($urandom_range(8193, 16382));
			default: return ENTRY_W'($urandom_range(0, 16383));
		endcase
	endfunction

	// Stimulus sequence and end of run.
	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Reset limits: range edges, free of a clear entry, first-fit reuse.
		wait_idle();
		@(posedge clk);
		queue_req(CMD_FREE, 1'b0, 14'd0);
		queue_req(CMD_FREE, 1'b1, 14'd16383);
		queue_req(CMD_FREE, 1'b0, 14'd8192);
		queue_req(CMD_FREE, 1'b1, 14'd8193);
		queue_req(CMD_ALLOC, 1'b0, 14'd16383);
		queue_req(CMD_ALLOC, 1'b0, 14'd0);
		queue_req(CMD_ALLOC, 1'b0, 14'd8192);
		queue_req(CMD_ALLOC, 1'b1, 14'd0);
		queue_req(CMD_FREE, 1'b0, 14'd2);
		queue_req(CMD_FREE, 1'b0, 14'd2);
		queue_req(CMD_ALLOC, 1'b0, 14'd0);

		// Shrunk block map and an inode map with no entries.
		set_spans(14'd2, 14'd0);
		queue_req(CMD_ALLOC, 1'b0, 14'd0);
		queue_req(CMD_FREE, 1'b0, 14'd3);
		queue_req(CMD_ALLOC, 1'b1, 14'd0);
		queue_req(CMD_FREE, 1'b1, 14'd1);
		queue_req(CMD_FREE, 1'b0, 14'd1);
		queue_req(CMD_ALLOC, 1'b0, 14'd0);

		// Oversized block register and a one-entry inode map.
		set_spans(14'd16383, 14'd1);
		queue_req(CMD_FREE, 1'b0, 14'd3);
		queue_req(CMD_FREE, 1'b0, 14'd8192);
		queue_req(CMD_ALLOC, 1'b1, 14'd0);
		queue_req(CMD_FREE, 1'b1, 14'd1);
		queue_req(CMD_ALLOC, 1'b1, 14'd0);

		// Random phases, each under freshly drawn limits.
		for (int p = 0; p < PHASES; p++) begin
			set_spans(draw_span_value(), draw_span_value());
			for (int k = 0; k < PHASE_ITEMS; k++)
				queue_random_req($urandom_range(0, 1));
		end

		wait_idle();
		repeat (300) @(negedge clk);
		if (awaited_answers.size() != 0) begin
			$error("%0d results never arrived", awaited_answers.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Hard stop in case the unit hangs.
	initial begin
		#(10_000_000);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: bitmap_first_fit_allocator_unit.f
rtl/bffa_pkg.sv
rtl/bitmap_first_fit_allocator_unit.sv
bench/tb.sv
